// ===== rtl/core/odq_pkg.sv =====
// ----------------------------------------------------------------------------
// odq_pkg
// Shared types and constants of the obstacle departure qualifier.
// ----------------------------------------------------------------------------
package odq_pkg;

    localparam int C_COORD_BITS  = 24;
    localparam int C_HALF_BITS   = 22;
    localparam int C_CNT_BITS    = 8;
    localparam int C_CFG_BITS    = 24;
    localparam int C_CFG_IDX     = 3;
    localparam int C_HALF2_BITS  = 25;
    localparam int C_ADIFF_BITS  = 26;
    localparam int C_DIST_BITS   = C_HALF_BITS + 1;
    localparam int C_SQ_BITS     = 2 * C_DIST_BITS;
    localparam int C_Q_DEPTH     = 2;
    localparam int C_Q_PTR_BITS  = 1;
    localparam int C_Q_CNT_BITS  = 2;

    localparam logic OP_OBSERVE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    localparam logic [C_CFG_IDX-1:0] REG_REGION_CX = 3'd0;
    localparam logic [C_CFG_IDX-1:0] REG_REGION_CY = 3'd1;
    localparam logic [C_CFG_IDX-1:0] REG_REGION_HX = 3'd2;
    localparam logic [C_CFG_IDX-1:0] REG_REGION_HY = 3'd3;
    localparam logic [C_CFG_IDX-1:0] REG_BLK_CX    = 3'd4;
    localparam logic [C_CFG_IDX-1:0] REG_BLK_CY    = 3'd5;
    localparam logic [C_CFG_IDX-1:0] REG_BLK_R     = 3'd6;
    localparam logic [C_CFG_IDX-1:0] REG_REQUIRED  = 3'd7;

    typedef enum logic [2:0] {
        ST_ABSENT   = 3'd0,
        ST_EXPIRED  = 3'd1,
        ST_OVERLAP  = 3'd2,
        ST_MOVED    = 3'd3,
        ST_DEPARTED = 3'd4,
        ST_RESTART  = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        K_RESTART = 3'd0,
        K_ABSENT  = 3'd1,
        K_EXPIRED = 3'd2,
        K_BLOCK   = 3'd3,
        K_EVAL    = 3'd4,
        K_FAR     = 3'd5,
        K_CIRCLE  = 3'd6
    } t_kind;

    typedef struct packed {
        logic                           operation;
        logic                           object_present;
        logic                           observation_expired;
        logic                           center_known;
        logic                           extent_known;
        logic signed [C_COORD_BITS-1:0] bbox_center_x;
        logic signed [C_COORD_BITS-1:0] bbox_center_y;
        logic signed [C_COORD_BITS-1:0] bbox_extent_x;
        logic signed [C_COORD_BITS-1:0] bbox_extent_y;
    } t_in_item;

    typedef struct packed {
        logic [2:0]            status_code;
        logic                  blocking;
        logic [C_CNT_BITS-1:0] clear_count;
        logic                  departed;
    } t_out_item;

    typedef struct packed {
        logic signed [C_COORD_BITS-1:0] region_cx;
        logic signed [C_COORD_BITS-1:0] region_cy;
        logic [C_HALF_BITS-1:0]         region_hx;
        logic [C_HALF_BITS-1:0]         region_hy;
        logic signed [C_COORD_BITS-1:0] blk_cx;
        logic signed [C_COORD_BITS-1:0] blk_cy;
        logic [C_HALF_BITS-1:0]         blk_r;
        logic [C_CNT_BITS-1:0]          required;
    } t_cfg;

    typedef struct packed {
        t_kind                  kind;
        logic [C_DIST_BITS-1:0] dx;
        logic [C_DIST_BITS-1:0] dy;
    } t_class;

endpackage

// ===== rtl/core/odq_front.sv =====
// ----------------------------------------------------------------------------
// odq_front
// Request intake: flag decode, footprint, box overlap and circle range test.
// ----------------------------------------------------------------------------
module odq_front #(
    parameter int FALLBACK_HALF_MM  = 200,
    parameter int OBJECT_PADDING_MM = 20
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  odq_pkg::t_in_item i_data,
    input  odq_pkg::t_cfg     i_cfg,
    input  logic              i_q_full,
    output logic              o_push,
    output odq_pkg::t_class   o_push_data
);
    import odq_pkg::*;

    localparam logic [C_HALF2_BITS-1:0] PAD2 = C_HALF2_BITS'(2 * OBJECT_PADDING_MM);
    localparam logic [C_HALF2_BITS-1:0] FB2  = C_HALF2_BITS'(2 * FALLBACK_HALF_MM);

    function automatic logic [C_ADIFF_BITS-1:0] abs_diff2(
        input logic signed [C_COORD_BITS-1:0] a,
        input logic signed [C_COORD_BITS-1:0] b
    );
        logic [C_ADIFF_BITS-1:0] d;
        d = {a[C_COORD_BITS-1], a, 1'b0} - {b[C_COORD_BITS-1], b, 1'b0};
        return d[C_ADIFF_BITS-1] ? C_ADIFF_BITS'(-d) : d;
    endfunction

    logic                    r_s1_valid;
    t_kind                   r_s1_kind;
    logic [C_HALF2_BITS-1:0] r_s1_hx;
    logic [C_HALF2_BITS-1:0] r_s1_hy;
    logic [C_ADIFF_BITS-1:0] r_s1_adr_x;
    logic [C_ADIFF_BITS-1:0] r_s1_adr_y;
    logic [C_ADIFF_BITS-1:0] r_s1_adb_x;
    logic [C_ADIFF_BITS-1:0] r_s1_adb_y;

    t_kind                   n_kind;
    logic [C_COORD_BITS-1:0] w_ax;
    logic [C_COORD_BITS-1:0] w_ay;
    logic                    w_ext_ok;
    logic [C_HALF2_BITS-1:0] n_hx;
    logic [C_HALF2_BITS-1:0] n_hy;

    logic [C_ADIFF_BITS-1:0] w_lim_x;
    logic [C_ADIFF_BITS-1:0] w_lim_y;
    logic                    w_box;
    logic [C_ADIFF_BITS:0]   w_d_x;
    logic [C_ADIFF_BITS:0]   w_d_y;
    logic [C_ADIFF_BITS-1:0] w_r2;
    logic                    w_far;
    t_kind                   w_kind;
    logic [C_DIST_BITS-1:0]  w_dx;
    logic [C_DIST_BITS-1:0]  w_dy;

    assign o_ready = !r_s1_valid || !i_q_full;

    always_comb begin
        w_ax = i_data.bbox_extent_x[C_COORD_BITS-1] ? C_COORD_BITS'(-i_data.bbox_extent_x)
                                                     : C_COORD_BITS'(i_data.bbox_extent_x);
        w_ay = i_data.bbox_extent_y[C_COORD_BITS-1] ? C_COORD_BITS'(-i_data.bbox_extent_y)
                                                     : C_COORD_BITS'(i_data.bbox_extent_y);
        w_ext_ok = i_data.extent_known && (w_ax != '0) && (w_ay != '0);
        n_hx = w_ext_ok ? ({1'b0, w_ax} + PAD2) : FB2;
        n_hy = w_ext_ok ? ({1'b0, w_ay} + PAD2) : FB2;
        if (i_data.operation == OP_RESTART) begin
            n_kind = K_RESTART;
        end else if (!i_data.object_present) begin
            n_kind = K_ABSENT;
        end else if (i_data.observation_expired) begin
            n_kind = K_EXPIRED;
        end else if (!i_data.center_known) begin
            n_kind = K_BLOCK;
        end else begin
            n_kind = K_EVAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_s1_kind  <= n_kind;
            r_s1_hx    <= n_hx;
            r_s1_hy    <= n_hy;
            r_s1_adr_x <= abs_diff2(i_data.bbox_center_x, i_cfg.region_cx);
            r_s1_adr_y <= abs_diff2(i_data.bbox_center_y, i_cfg.region_cy);
            r_s1_adb_x <= abs_diff2(i_cfg.blk_cx, i_data.bbox_center_x);
            r_s1_adb_y <= abs_diff2(i_cfg.blk_cy, i_data.bbox_center_y);
        end
    end

    always_comb begin
        w_lim_x = C_ADIFF_BITS'(r_s1_hx) + C_ADIFF_BITS'({i_cfg.region_hx, 1'b0});
        w_lim_y = C_ADIFF_BITS'(r_s1_hy) + C_ADIFF_BITS'({i_cfg.region_hy, 1'b0});
        w_box   = (r_s1_adr_x <= w_lim_x) && (r_s1_adr_y <= w_lim_y);
        w_d_x   = {1'b0, r_s1_adb_x} - (C_ADIFF_BITS + 1)'(r_s1_hx);
        w_d_y   = {1'b0, r_s1_adb_y} - (C_ADIFF_BITS + 1)'(r_s1_hy);
        w_r2    = C_ADIFF_BITS'({i_cfg.blk_r, 1'b0});
        w_far   = (!w_d_x[C_ADIFF_BITS] && (w_d_x[C_ADIFF_BITS-1:0] > w_r2)) ||
                  (!w_d_y[C_ADIFF_BITS] && (w_d_y[C_ADIFF_BITS-1:0] > w_r2));
        w_dx    = w_d_x[C_ADIFF_BITS] ? '0 : w_d_x[C_DIST_BITS-1:0];
        w_dy    = w_d_y[C_ADIFF_BITS] ? '0 : w_d_y[C_DIST_BITS-1:0];
        w_kind  = r_s1_kind;
        if (r_s1_kind == K_EVAL) begin
            if (w_box) begin
                w_kind = K_BLOCK;
            end else if (w_far) begin
                w_kind = K_FAR;
            end else begin
                w_kind = K_CIRCLE;
            end
        end
    end

    assign o_push      = r_s1_valid;
    assign o_push_data = '{kind: w_kind, dx: w_dx, dy: w_dy};

endmodule

// ===== rtl/core/odq_queue.sv =====
// ----------------------------------------------------------------------------
// odq_queue
// Two-entry queue of classified requests between intake and evaluation.
// ----------------------------------------------------------------------------
module odq_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  odq_pkg::t_class i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output odq_pkg::t_class o_pop_data
);
    import odq_pkg::*;

    t_class                  r_mem [C_Q_DEPTH];
    logic [C_Q_PTR_BITS-1:0] r_wr_ptr;
    logic [C_Q_PTR_BITS-1:0] r_rd_ptr;
    logic [C_Q_CNT_BITS-1:0] r_count;
    logic                    w_wr;
    logic                    w_rd;

    assign o_full     = (r_count == C_Q_CNT_BITS'(C_Q_DEPTH));
    assign o_empty    = (r_count == '0);
    assign w_wr       = i_push && !o_full;
    assign w_rd       = i_pop && !o_empty;
    assign o_pop_data = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/core/odq_back.sv =====
// ----------------------------------------------------------------------------
// odq_back
// Evaluation: squared circle distance, clear streak and result register.
// ----------------------------------------------------------------------------
module odq_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  odq_pkg::t_class    i_q_data,
    output logic               o_pop,
    input  odq_pkg::t_cfg      i_cfg,
    output logic               o_valid,
    input  logic               i_ready,
    output odq_pkg::t_out_item o_data
);
    import odq_pkg::*;

    logic                   r_m_valid;
    t_kind                  r_m_kind;
    logic [C_SQ_BITS-1:0]   r_m_dxsq;
    logic [C_SQ_BITS-1:0]   r_m_dysq;
    logic [C_SQ_BITS-1:0]   r_m_rsq;
    logic                   r_o_valid;
    t_out_item              r_out;
    logic [C_CNT_BITS-1:0]  r_streak;

    logic                   w_adv_o;
    logic                   w_adv_m;
    logic [C_DIST_BITS-1:0] w_r;
    logic [C_SQ_BITS:0]     w_sum;
    logic                   w_block;
    t_status                w_base;
    logic [C_CNT_BITS-1:0]  w_inc;
    logic [C_CNT_BITS-1:0]  w_need;
    logic                   w_done;
    logic [C_CNT_BITS-1:0]  n_streak;
    t_out_item              n_out;

    assign w_adv_o = !r_o_valid || i_ready;
    assign w_adv_m = !r_m_valid || w_adv_o;
    assign o_pop   = !i_q_empty && w_adv_m;
    assign w_r     = {i_cfg.blk_r, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_adv_m) begin
            r_m_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_m_kind <= i_q_data.kind;
            r_m_dxsq <= i_q_data.dx * i_q_data.dx;
            r_m_dysq <= i_q_data.dy * i_q_data.dy;
            r_m_rsq  <= w_r * w_r;
        end
    end

    always_comb begin
        w_sum = (C_SQ_BITS + 1)'(r_m_dxsq) + (C_SQ_BITS + 1)'(r_m_dysq);
        case (r_m_kind)
            K_BLOCK: begin
                w_block = 1'b1;
                w_base  = ST_OVERLAP;
            end
            K_CIRCLE: begin
                w_block = (w_sum <= (C_SQ_BITS + 1)'(r_m_rsq));
                w_base  = w_block ? ST_OVERLAP : ST_MOVED;
            end
            K_ABSENT: begin
                w_block = 1'b0;
                w_base  = ST_ABSENT;
            end
            K_EXPIRED: begin
                w_block = 1'b0;
                w_base  = ST_EXPIRED;
            end
            default: begin
                w_block = 1'b0;
                w_base  = ST_MOVED;
            end
        endcase
        w_inc  = (r_streak == '1) ? r_streak : r_streak + 1'b1;
        w_need = (i_cfg.required == '0) ? C_CNT_BITS'(1) : i_cfg.required;
        w_done = (w_inc >= w_need);
        if (r_m_kind == K_RESTART) begin
            n_streak = '0;
            n_out    = '{status_code: ST_RESTART, blocking: 1'b0,
                         clear_count: '0, departed: 1'b0};
        end else if (w_block) begin
            n_streak = '0;
            n_out    = '{status_code: w_base, blocking: 1'b1,
                         clear_count: '0, departed: 1'b0};
        end else begin
            n_streak = w_inc;
            n_out    = '{status_code: w_done ? ST_DEPARTED : w_base, blocking: 1'b0,
                         clear_count: w_inc, departed: w_done};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_streak  <= '0;
        end else if (w_adv_o) begin
            r_o_valid <= r_m_valid;
            if (r_m_valid) begin
                r_streak <= n_streak;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv_o && r_m_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_out;

endmodule

// ===== rtl/core/obstacle_departure_qualifier.sv =====
// ----------------------------------------------------------------------------
// obstacle_departure_qualifier
// Qualifies tracked-object observations and reports when the object has left.
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_data   (t_in_item)
//  result    out        o_valid / i_ready    o_data   (t_out_item)
//  config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
//  One request per cycle sustained while i_ready is high; a request passes the
//  intake register, queue, multiplier register and result register in turn.
//  Synchronous active-low reset clears control state and streak, and loads config defaults.
//  A stalled result fills the two-entry queue, then o_ready drops.
// ----------------------------------------------------------------------------
module obstacle_departure_qualifier #(
    parameter int FALLBACK_HALF_MM  = 200,
    parameter int OBJECT_PADDING_MM = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  odq_pkg::t_in_item                  i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output odq_pkg::t_out_item                 o_data,
    input  logic                               i_cfg_we,
    input  logic [odq_pkg::C_CFG_IDX-1:0]      i_cfg_idx,
    input  logic [odq_pkg::C_CFG_BITS-1:0]     i_cfg_data
);
    import odq_pkg::*;

    t_cfg   r_cfg;
    logic   w_push;
    t_class w_push_data;
    logic   w_q_full;
    logic   w_q_empty;
    logic   w_pop;
    t_class w_pop_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.region_cx <= '0;
            r_cfg.region_cy <= '0;
            r_cfg.region_hx <= C_HALF_BITS'(300);
            r_cfg.region_hy <= C_HALF_BITS'(300);
            r_cfg.blk_cx    <= '0;
            r_cfg.blk_cy    <= '0;
            r_cfg.blk_r     <= C_HALF_BITS'(200);
            r_cfg.required  <= C_CNT_BITS'(3);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_REGION_CX: r_cfg.region_cx <= i_cfg_data[C_COORD_BITS-1:0];
                REG_REGION_CY: r_cfg.region_cy <= i_cfg_data[C_COORD_BITS-1:0];
                REG_REGION_HX: r_cfg.region_hx <= i_cfg_data[C_HALF_BITS-1:0];
                REG_REGION_HY: r_cfg.region_hy <= i_cfg_data[C_HALF_BITS-1:0];
                REG_BLK_CX:    r_cfg.blk_cx    <= i_cfg_data[C_COORD_BITS-1:0];
                REG_BLK_CY:    r_cfg.blk_cy    <= i_cfg_data[C_COORD_BITS-1:0];
                REG_BLK_R:     r_cfg.blk_r     <= i_cfg_data[C_HALF_BITS-1:0];
                REG_REQUIRED:  r_cfg.required  <= i_cfg_data[C_CNT_BITS-1:0];
            endcase
        end
    end

    odq_front #(
        .FALLBACK_HALF_MM  (FALLBACK_HALF_MM),
        .OBJECT_PADDING_MM (OBJECT_PADDING_MM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .i_cfg       (r_cfg),
        .i_q_full    (w_q_full),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    odq_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_q_full),
        .i_pop       (w_pop),
        .o_empty     (w_q_empty),
        .o_pop_data  (w_pop_data)
    );

    odq_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (w_q_empty),
        .i_q_data  (w_pop_data),
        .o_pop     (w_pop),
        .i_cfg     (r_cfg),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_data    (o_data)
    );

    a_block_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.blocking |-> o_data.clear_count == '0 && !o_data.departed)
        else $error("blocking result with non-zero streak");

    a_departed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.departed |->
            o_data.status_code == ST_DEPARTED && o_data.clear_count != '0)
        else $error("departure reported with wrong status or empty streak");

    a_push_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push && w_q_full |=> w_push)
        else $error("classified request lost while queue full");

    a_restart_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.status_code == ST_RESTART |->
            !o_data.blocking && o_data.clear_count == '0 && !o_data.departed)
        else $error("restart result with stale fields");

endmodule
